// ===== hw/rtl/chti_pkg.sv =====
`default_nettype none

package chti_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PTS_W     = 11;
    localparam int ADDR_W    = 11;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RECIP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS      = 2'd2;

    localparam logic signed [WORD_W-1:0] TABLE_START_RST = 32'sd0;
    localparam logic [WORD_W-1:0]        STEP_RECIP_RST  = 32'd65536;
    localparam logic [PTS_W-1:0]         POINTS_RST      = 11'd1024;

    // request functions
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // table banks, selected by {point parity, word kind}
    localparam int BANK_Y_EVEN = 0;
    localparam int BANK_D_EVEN = 1;
    localparam int BANK_Y_ODD  = 2;
    localparam int BANK_D_ODD  = 3;
    localparam int BANKS       = 4;

    typedef struct packed {
        logic signed [WORD_W-1:0] table_start;
        logic [WORD_W-1:0]        step_recip;
        logic [PTS_W-1:0]         points;
    } t_cfg;

    typedef struct packed {
        logic              vld;
        logic              oor;
        logic              odd;
        logic [FRAC_W-1:0] t;
    } t_blend_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/cubic_hermite_table_interpolator.sv =====
`default_nettype none

// An evaluate request passes front stages A-C and blend stages D-G into the output register.
// Throughput: one request per cycle, loads and evaluates mixed freely; busy is low outside reset.
// Rate is set by the single 32x32 index multiplier stage and the four-bank table, which
// delivers both neighbor points in one registered read. The receiver cannot stall.
// Reset: config registers return to their defaults and the pipeline empties; table
// contents stay undefined until loaded.

module cubic_hermite_table_interpolator #(
    parameter int TABLE_POINTS = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // request channel
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_func,
    input  wire logic [chti_pkg::ADDR_W-1:0]            i_word_address,
    input  wire logic signed [chti_pkg::WORD_W-1:0]     i_word_value,
    input  wire logic signed [chti_pkg::WORD_W-1:0]     i_x_value,
    // result channel
    output logic                                        o_strobe,
    output logic signed [chti_pkg::WORD_W-1:0]          o_result_value,
    output logic                                        o_out_of_range,
    // configuration write channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [chti_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [chti_pkg::WORD_W-1:0]            i_cfg_data
);

    // Each table point p goes to a bank chosen by its parity, with value and
    // derivative in separate banks, so points i and i+1 always sit in
    // different banks and read together.
    localparam int DEPTH = (TABLE_POINTS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);

    chti_pkg::t_cfg              r_cfg;
    chti_pkg::t_blend_ctl        ctl;
    logic                        req;
    logic [chti_pkg::BANKS-1:0]  we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr_even;
    logic [AW-1:0]               raddr_odd;
    logic [chti_pkg::WORD_W-1:0] wdata;
    logic [chti_pkg::WORD_W-1:0] y_even, d_even, y_odd, d_odd;

    // The pipeline never stalls: accept a request in every cycle outside reset.
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign req         = start && !busy;

    // Configuration registers; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.table_start <= chti_pkg::TABLE_START_RST;
            r_cfg.step_recip  <= chti_pkg::STEP_RECIP_RST;
            r_cfg.points      <= chti_pkg::POINTS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                chti_pkg::CFG_TABLE_START: begin
                    r_cfg.table_start <= i_cfg_data;
                end
                chti_pkg::CFG_STEP_RECIP: begin
                    r_cfg.step_recip <= i_cfg_data;
                end
                chti_pkg::CFG_POINTS: begin
                    r_cfg.points <= i_cfg_data[chti_pkg::PTS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Offset, scale, guard and table addressing. Loads travel to the read
    // stage before they write, so every request sees the table in order.
    chti_front #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_req          (req),
        .i_func         (i_func),
        .i_word_address (i_word_address),
        .i_word_value   (i_word_value),
        .i_x_value      (i_x_value),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr_even   (raddr_even),
        .o_raddr_odd    (raddr_odd),
        .o_ctl          (ctl)
    );

    chti_ram #(
        .WIDTH (chti_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_y_even (
        .i_clk   (i_clk),
        .i_we    (we[chti_pkg::BANK_Y_EVEN]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_even),
        .o_rdata (y_even)
    );

    chti_ram #(
        .WIDTH (chti_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_d_even (
        .i_clk   (i_clk),
        .i_we    (we[chti_pkg::BANK_D_EVEN]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_even),
        .o_rdata (d_even)
    );

    chti_ram #(
        .WIDTH (chti_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_y_odd (
        .i_clk   (i_clk),
        .i_we    (we[chti_pkg::BANK_Y_ODD]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_odd),
        .o_rdata (y_odd)
    );

    chti_ram #(
        .WIDTH (chti_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram_d_odd (
        .i_clk   (i_clk),
        .i_we    (we[chti_pkg::BANK_D_ODD]),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_odd),
        .o_rdata (d_odd)
    );

    // Hermite blend: basis setup, one multiply per path per stage, then
    // sum and saturate into the output register.
    chti_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_y_even       (y_even),
        .i_d_even       (d_even),
        .i_y_odd        (y_odd),
        .i_d_odd        (d_odd),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_out_of_range (o_out_of_range)
    );

    a_oor_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out_of_range) |-> (o_result_value == '0))
        else $error("flagged result is not zero");

endmodule

`default_nettype wire

// ===== hw/rtl/chti_ram.sv =====
`default_nettype none

module chti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/chti_front.sv =====
`default_nettype none

module chti_front #(
    parameter int TABLE_POINTS = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire chti_pkg::t_cfg                         i_cfg,
    input  wire logic                                   i_req,
    input  wire logic                                   i_func,
    input  wire logic [chti_pkg::ADDR_W-1:0]            i_word_address,
    input  wire logic signed [chti_pkg::WORD_W-1:0]     i_word_value,
    input  wire logic signed [chti_pkg::WORD_W-1:0]     i_x_value,
    output logic [chti_pkg::BANKS-1:0]                  o_we,
    output logic [$clog2((TABLE_POINTS+1)/2)-1:0]       o_waddr,
    output logic [chti_pkg::WORD_W-1:0]                 o_wdata,
    output logic [$clog2((TABLE_POINTS+1)/2)-1:0]       o_raddr_even,
    output logic [$clog2((TABLE_POINTS+1)/2)-1:0]       o_raddr_odd,
    output chti_pkg::t_blend_ctl                        o_ctl
);

    localparam int DEPTH = (TABLE_POINTS + 1) / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int WORDS = 2 * TABLE_POINTS;

    // stage A: offset from the table start
    logic                          r_a_vld;
    logic                          r_a_func;
    logic [chti_pkg::ADDR_W-1:0]   r_a_addr;
    logic [chti_pkg::WORD_W-1:0]   r_a_wdata;
    logic                          r_a_neg;
    logic [chti_pkg::WORD_W-1:0]   r_a_diff;
    logic [chti_pkg::WORD_W:0]     n_a_diff;

    // stage B: scaled position
    logic                          r_b_vld;
    logic                          r_b_func;
    logic [chti_pkg::ADDR_W-1:0]   r_b_addr;
    logic [chti_pkg::WORD_W-1:0]   r_b_wdata;
    logic                          r_b_neg;
    logic [2*chti_pkg::WORD_W-1:0] r_b_prod;

    logic [chti_pkg::WORD_W-1:0]   n_b_idx;
    logic [chti_pkg::PTS_W-1:0]    n_b_lim;
    logic                          n_b_oor;
    logic [31:0]                   n_b_wa;
    logic                          n_b_wr;

    chti_pkg::t_blend_ctl          r_c;

    assign n_a_diff = {i_x_value[chti_pkg::WORD_W-1], i_x_value}
                    - {i_cfg.table_start[chti_pkg::WORD_W-1], i_cfg.table_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_req;
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_func  <= i_func;
        r_a_addr  <= i_word_address;
        r_a_wdata <= i_word_value;
        r_a_neg   <= n_a_diff[chti_pkg::WORD_W];
        r_a_diff  <= n_a_diff[chti_pkg::WORD_W-1:0];

        r_b_func  <= r_a_func;
        r_b_addr  <= r_a_addr;
        r_b_wdata <= r_a_wdata;
        r_b_neg   <= r_a_neg;
        r_b_prod  <= {32'd0, r_a_diff} * {32'd0, i_cfg.step_recip};
    end

    // guard and bank addressing
    always_comb begin
        n_b_idx = r_b_prod[2*chti_pkg::WORD_W-1:chti_pkg::WORD_W];
        if (32'(i_cfg.points) > TABLE_POINTS) begin
            n_b_lim = chti_pkg::PTS_W'(TABLE_POINTS);
        end else begin
            n_b_lim = i_cfg.points;
        end
        n_b_oor = r_b_neg || (n_b_idx < 32'd2)
               || (({1'b0, n_b_idx} + 33'd3) > 33'(n_b_lim));

        n_b_wa = 32'(r_b_addr);
        n_b_wr = r_b_vld && (r_b_func == chti_pkg::FUNC_LOAD) && (n_b_wa < 32'(WORDS));
        for (int k = 0; k < chti_pkg::BANKS; k++) begin
            o_we[k] = n_b_wr && (n_b_wa[1:0] == 2'(k));
        end
    end

    assign o_waddr      = n_b_wa[AW+1:2];
    assign o_wdata      = r_b_wdata;
    assign o_raddr_odd  = n_b_idx[AW:1];
    assign o_raddr_even = n_b_idx[AW:1] + AW'(n_b_idx[0]);

    // stage C: control aligned with the registered table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else begin
            r_c.vld <= r_b_vld && (r_b_func == chti_pkg::FUNC_EVAL);
            r_c.oor <= n_b_oor;
            r_c.odd <= n_b_idx[0];
            r_c.t   <= r_b_prod[chti_pkg::WORD_W-1:chti_pkg::WORD_W-chti_pkg::FRAC_W];
        end
    end

    assign o_ctl = r_c;

    a_load_no_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && (r_b_func == chti_pkg::FUNC_LOAD)) |=> !r_c.vld)
        else $error("load request reached the blend stages");

    a_eval_reaches_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && (r_b_func == chti_pkg::FUNC_EVAL)) |=> r_c.vld)
        else $error("evaluate request dropped before the blend stages");

endmodule

`default_nettype wire

// ===== hw/rtl/chti_blend.sv =====
`default_nettype none

module chti_blend (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire chti_pkg::t_blend_ctl               i_ctl,
    input  wire logic [chti_pkg::WORD_W-1:0]        i_y_even,
    input  wire logic [chti_pkg::WORD_W-1:0]        i_d_even,
    input  wire logic [chti_pkg::WORD_W-1:0]        i_y_odd,
    input  wire logic [chti_pkg::WORD_W-1:0]        i_d_odd,
    output logic                                    o_strobe,
    output logic signed [chti_pkg::WORD_W-1:0]      o_result_value,
    output logic                                    o_out_of_range
);

    localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

    // stage D
    logic [31:0]        n_d_ylo, n_d_dlo, n_d_yhi, n_d_dhi;
    logic [16:0]        n_d_s;
    logic               r_d_vld, r_d_oor;
    logic signed [16:0] r_d_ts;
    logic signed [17:0] r_d_ss;
    logic signed [31:0] r_d_ylo, r_d_yhi;
    logic signed [33:0] r_d_a, r_d_b;

    // stage E
    logic signed [50:0] n_e_lo, n_e_hi;
    logic               r_e_vld, r_e_oor;
    logic signed [16:0] r_e_ts;
    logic signed [17:0] r_e_ss;
    logic signed [34:0] r_e_lo, r_e_hi;

    // stage F
    logic signed [50:0] n_f_lo, n_f_hi;
    logic               r_f_vld, r_f_oor;
    logic signed [16:0] r_f_ts;
    logic signed [17:0] r_f_ss;
    logic signed [34:0] r_f_lo, r_f_hi;

    // stage G
    logic signed [50:0] n_g_lo, n_g_hi;
    logic               r_g_vld, r_g_oor;
    logic signed [34:0] r_g_lo, r_g_hi;

    // output
    logic signed [35:0] n_h_sum;
    logic signed [31:0] n_h_sat;
    logic               r_strobe, r_oor;
    logic signed [31:0] r_res;

    always_comb begin
        if (i_ctl.odd) begin
            n_d_ylo = i_y_odd;
            n_d_dlo = i_d_odd;
            n_d_yhi = i_y_even;
            n_d_dhi = i_d_even;
        end else begin
            n_d_ylo = i_y_even;
            n_d_dlo = i_d_even;
            n_d_yhi = i_y_odd;
            n_d_dhi = i_d_odd;
        end
        n_d_s = 17'd65536 - {1'b0, i_ctl.t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld  <= 1'b0;
            r_e_vld  <= 1'b0;
            r_f_vld  <= 1'b0;
            r_g_vld  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_d_vld  <= i_ctl.vld;
            r_e_vld  <= r_d_vld;
            r_f_vld  <= r_e_vld;
            r_g_vld  <= r_f_vld;
            r_strobe <= r_g_vld;
        end
    end

    // products of each stage, floor-shifted by the fraction width
    always_comb begin
        n_e_lo = 51'(r_d_ts) * 51'(r_d_a) + {{3{r_d_ylo[31]}}, r_d_ylo, 16'd0};
        n_e_hi = 51'(r_d_ss) * 51'(r_d_b) + {{3{r_d_yhi[31]}}, r_d_yhi, 16'd0};
        n_f_lo = 51'(r_e_lo) * 51'(r_e_ss);
        n_f_hi = 51'(r_e_hi) * 51'(r_e_ts);
        n_g_lo = 51'(r_f_lo) * 51'(r_f_ss);
        n_g_hi = 51'(r_f_hi) * 51'(r_f_ts);
        n_h_sum = 36'(r_g_lo) + 36'(r_g_hi);
        if (n_h_sum > SAT_MAX) begin
            n_h_sat = SAT_MAX[31:0];
        end else if (n_h_sum < SAT_MIN) begin
            n_h_sat = SAT_MIN[31:0];
        end else begin
            n_h_sat = n_h_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_oor <= i_ctl.oor;
        r_d_ts  <= {1'b0, i_ctl.t};
        r_d_ss  <= {1'b0, n_d_s};
        r_d_ylo <= n_d_ylo;
        r_d_yhi <= n_d_yhi;
        r_d_a   <= {n_d_ylo[31], n_d_ylo, 1'b0} + {{2{n_d_dlo[31]}}, n_d_dlo};
        r_d_b   <= {n_d_yhi[31], n_d_yhi, 1'b0} - {{2{n_d_dhi[31]}}, n_d_dhi};

        r_e_oor <= r_d_oor;
        r_e_ts  <= r_d_ts;
        r_e_ss  <= r_d_ss;
        r_e_lo  <= n_e_lo[50:16];
        r_e_hi  <= n_e_hi[50:16];

        r_f_oor <= r_e_oor;
        r_f_ts  <= r_e_ts;
        r_f_ss  <= r_e_ss;
        r_f_lo  <= n_f_lo[50:16];
        r_f_hi  <= n_f_hi[50:16];

        r_g_oor <= r_f_oor;
        r_g_lo  <= n_g_lo[50:16];
        r_g_hi  <= n_g_hi[50:16];

        r_oor   <= r_g_oor;
        r_res   <= r_g_oor ? 32'sd0 : n_h_sat;
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_res;
    assign o_out_of_range = r_oor;

    a_ctl_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.vld |-> ##5 o_strobe)
        else $error("blend pipeline lost a request");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

localparam int TB_TABLE_POINTS = 1024;

typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
} t_hermite_result;

// Mirror of the block: registers, table contents and the results still due.
class hermite_checker;
    logic signed [31:0] start_x;
    logic [31:0]        recip;
    logic [10:0]        points;
    logic signed [31:0] table_mirror [0:2*TB_TABLE_POINTS-1];
    t_hermite_result    pending_values [$];
    int                 errors = 0;

    function void reset_regs();
        start_x = chti_pkg::TABLE_START_RST;
        recip   = chti_pkg::STEP_RECIP_RST;
        points  = chti_pkg::POINTS_RST;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            chti_pkg::CFG_TABLE_START: start_x = data;
            chti_pkg::CFG_STEP_RECIP:  recip = data;
            chti_pkg::CFG_POINTS:      points = data[10:0];
            default: ;
        endcase
    endfunction

    // Point index of x, or -1 when the guard flags it; frac is the 16-bit blend weight.
    function longint span_index(input logic signed [31:0] x, output logic [15:0] frac);
        longint     diff;
        longint     idx;
        longint     n;
        logic [63:0] prod;
        diff = longint'(x) - longint'(start_x);
        frac = '0;
        if (diff < 0)
            return -1;
        prod = {32'b0, diff[31:0]} * {32'b0, recip};
        frac = prod[31:16];
        idx  = longint'(prod[63:32]);
        n    = (points > TB_TABLE_POINTS) ? TB_TABLE_POINTS : longint'(points);
        if (idx < 2 || idx + 3 > n)
            return -1;
        return idx;
    endfunction

    function longint hermite_blend(input longint yl, input longint dl, input longint yh,
                                   input longint dh, input longint t);
        longint s, a, b, lo, hi;
        s  = 65536 - t;
        a  = 2 * yl + dl;
        b  = 2 * yh - dh;
        lo = (yl * 65536 + t * a) >>> 16;
        hi = (yh * 65536 + s * b) >>> 16;
        lo = (((lo * s) >>> 16) * s) >>> 16;
        hi = (((hi * t) >>> 16) * t) >>> 16;
        return lo + hi;
    endfunction

    function void note_request(input logic func, input logic [10:0] addr,
                               input logic signed [31:0] wv, input logic signed [31:0] x);
        longint          idx;
        longint          r;
        logic [15:0]     frac;
        int              base;
        t_hermite_result res;
        if (func == chti_pkg::FUNC_LOAD) begin
            table_mirror[addr] = wv;
            return;
        end
        idx = span_index(x, frac);
        if (idx < 0) begin
            res.value = '0;
            res.flag  = 1'b1;
        end else begin
            base = int'(2 * idx);
            r = hermite_blend(longint'(table_mirror[base]), longint'(table_mirror[base+1]),
                              longint'(table_mirror[base+2]), longint'(table_mirror[base+3]),
                              longint'(frac));
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            res.value = r[31:0];
            res.flag  = 1'b0;
        end
        pending_values.push_back(res);
    endfunction

    function void check_result(input logic signed [31:0] value, input logic flag);
        t_hermite_result want;
        if (pending_values.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual %0d flag %b",
                     $time, value, flag);
            return;
        end
        want = pending_values.pop_front();
        if (value !== want.value) begin
            errors++;
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, want.value, value);
        end
        if (flag !== want.flag) begin
            errors++;
            $display("%0t: out_of_range mismatch: expected %b, actual %b",
                     $time, want.flag, flag);
        end
    endfunction

    function int outstanding();
        return pending_values.size();
    endfunction
endclass

module tb_top;

    localparam int              CYCLE_LIMIT  = 400000;
    localparam int              DRAIN_CYCLES = 16;
    // the block has no register behind this index; writes to it must be ignored
    localparam logic [1:0]      CFG_UNUSED   = 2'd3;
    localparam logic [31:0]     WORD_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0]     WORD_MIN     = 32'h8000_0000;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                start          = 1'b0;
    logic                                busy;
    logic                                i_func         = chti_pkg::FUNC_LOAD;
    logic [chti_pkg::ADDR_W-1:0]         i_word_address = '0;
    logic signed [chti_pkg::WORD_W-1:0]  i_word_value   = '0;
    logic signed [chti_pkg::WORD_W-1:0]  i_x_value      = '0;
    logic                                o_strobe;
    logic signed [chti_pkg::WORD_W-1:0]  o_result_value;
    logic                                o_out_of_range;
    logic                                i_cfg_valid    = 1'b0;
    logic                                o_cfg_ready;
    logic [chti_pkg::CFG_IDX_W-1:0]      i_cfg_index    = '0;
    logic [chti_pkg::WORD_W-1:0]         i_cfg_data     = '0;

    hermite_checker             sb;
    int                         idle_pct    = 0;
    int                         cycle_count = 0;
    // every request accepted so far, loads and evaluates alike
    int                         sent_count  = 0;
    // words loaded since reset; an in-span evaluate may only touch these
    bit                         table_loaded [0:2*TB_TABLE_POINTS-1];

    cubic_hermite_table_interpolator #(
        .TABLE_POINTS   (TB_TABLE_POINTS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_word_address (i_word_address),
        .i_word_value   (i_word_value),
        .i_x_value      (i_x_value),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Check every strobed result against the oldest prediction; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_result_value, o_out_of_range);
    end

    // Table words: extremes, values in [-2^30, 2^30), and raw random patterns.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2, 3:    return $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Present one request, idling at random first, and hold it until busy is low at an edge.
    task automatic send_request(input logic func, input logic [10:0] addr,
                                input logic signed [31:0] wv, input logic signed [31:0] x);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= func;
        i_word_address <= addr;
        i_word_value   <= wv;
        i_x_value      <= x;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_request(func, addr, wv, x);
        sent_count++;
    endtask

    task automatic load_word(input logic [10:0] addr, input logic [31:0] value);
        send_request(chti_pkg::FUNC_LOAD, addr, value, $urandom);
        table_loaded[addr] = 1'b1;
    endtask

    // Evaluate at x; first load any neighbor word the blend would read that is still unset.
    task automatic eval_at(input logic signed [31:0] x);
        longint      idx;
        logic [15:0] frac;
        int          k;
        idx = sb.span_index(x, frac);
        if (idx >= 0) begin
            for (k = 0; k < 4; k++) begin
                if (!table_loaded[int'(2 * idx) + k])
                    load_word(11'(int'(2 * idx) + k), random_word());
            end
        end
        send_request(chti_pkg::FUNC_EVAL, 11'($urandom_range(0, 2047)), $urandom, x);
    endtask

    // Drop start, wait for every result, then let trailing loads leave the pipeline.
    task automatic wait_quiet();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; valid stays high so back-to-back writes never toggle it in a step.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(input logic [31:0] ts, input logic [31:0] recip,
                                input logic [10:0] n);
        cfg_write(chti_pkg::CFG_TABLE_START, ts);
        cfg_write(chti_pkg::CFG_STEP_RECIP, recip);
        cfg_write(chti_pkg::CFG_POINTS, {21'b0, n});
        cfg_write(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly evaluates aimed into the guarded span; the rest loads, wild and near-start x.
    // The count covers every request sent, neighbor loads included.
    task automatic run_random(input int count);
        int                 stop, sel, n, pt;
        logic [31:0]        fr;
        logic [63:0]        target, d;
        logic signed [31:0] x;
        stop = sent_count + count;
        while (sent_count < stop) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                load_word(11'($urandom_range(0, 2047)), random_word());
            end else if (sel < 30) begin
                eval_at($urandom);
            end else if (sel < 38) begin
                eval_at(sb.start_x + $urandom_range(0, 8) - 4);
            end else begin
                n = (sb.points > TB_TABLE_POINTS) ? TB_TABLE_POINTS : int'(sb.points);
                if (n >= 5 && $urandom_range(0, 9) < 8)
                    pt = $urandom_range(2, n - 3);
                else
                    pt = $urandom_range(0, n + 1);
                case ($urandom_range(0, 3))
                    0:       fr = 32'h0000_0000;
                    1:       fr = 32'hFFFF_FFFF;
                    default: fr = $urandom;
                endcase
                // pick the smallest offset whose scaled value reaches the target point
                target = (64'(pt) << 32) | 64'(fr);
                d = (target + 64'(sb.recip) - 64'd1) / 64'(sb.recip);
                if (d > 64'hFFFF_FFFF)
                    x = $urandom;
                else
                    x = sb.start_x + d[31:0];
                eval_at(x);
            end
        end
    endtask

    initial begin
        int p;
        sb = new;
        sb.reset_regs();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < 8; p++) begin
            // sender idles lightly, then heavily, then not at all
            idle_pct = (p < 3) ? 15 : ((p < 6) ? 61 : 0);
            wait_quiet();
            case (p)
                1: apply_config(WORD_MAX, 32'd1, 11'd4);
                2: apply_config($urandom_range(0, 200 << 16) - (100 << 16),
                                $urandom_range(1 << 14, 1 << 18), 11'd1024);
                3: apply_config(WORD_MIN, 32'hFFFF_FFFF, 11'd1024);
                4: apply_config($urandom, $urandom_range(1 << 12, 1 << 20), 11'd5);
                5: apply_config($urandom_range(0, 200 << 16) - (100 << 16),
                                $urandom_range(1, 32'hFFFF_FFFF),
                                11'($urandom_range(4, 1024)));
                6: apply_config($urandom_range(0, 200 << 16) - (100 << 16), 32'd65536,
                                11'($urandom_range(4, 1024)));
                7: apply_config($urandom, $urandom_range(1 << 10, 1 << 24), 11'd1024);
                default: ;
            endcase

            if (p == 0) begin
                // reset settings: x is the point index in Q16.16
                // positive saturation between points two and three
                load_word(11'd4, WORD_MAX);
                load_word(11'd5, WORD_MAX);
                load_word(11'd6, WORD_MAX);
                load_word(11'd7, WORD_MIN);
                eval_at(32'h0002_8000);
                eval_at(32'h0002_0000);
                eval_at(32'h0002_FFFF);
                // negative saturation between points four and five
                load_word(11'd8, WORD_MIN);
                load_word(11'd9, WORD_MIN);
                load_word(11'd10, WORD_MIN);
                load_word(11'd11, WORD_MAX);
                eval_at(32'h0004_8000);
                // below start, far above the span, and both edges of the guard
                eval_at(WORD_MIN);
                eval_at(WORD_MAX);
                eval_at(32'h0000_0000);
                eval_at(32'h0001_FFFF);
                eval_at(32'h03FD_8000);
                eval_at(32'h03FE_0000);
                load_word(11'd0, 32'h0000_0000);
                load_word(11'd2047, WORD_MAX);
            end

            case (p)
                0:       run_random(236);
                1:       run_random(100);
                3, 4:    run_random(200);
                7:       run_random(264);
                default: run_random(300);
            endcase
        end

        wait_quiet();
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
